// ===== sv/asg_pkg.sv =====
// Shared types and constants for the audio squelch gate with preroll.
// Used by the front, queue, back and top-level modules.
package asg_pkg;

  localparam int HIST_DEPTH_DEF = 64;
  localparam int QUEUE_DEPTH    = 2;

  // register indexes on the config port
  localparam logic [2:0] CFG_THRESHOLD = 3'd0;
  localparam logic [2:0] CFG_HANGOVER  = 3'd1;
  localparam logic [2:0] CFG_PREROLL_N = 3'd2;
  localparam logic [2:0] CFG_PREROLL_EN = 3'd3;
  localparam logic [2:0] CFG_STEREO    = 3'd4;
  localparam logic [2:0] CFG_EIGHT_BIT = 3'd5;

  localparam logic [1:0] CH_NONE  = 2'd0;
  localparam logic [1:0] CH_LEFT  = 2'd1;
  localparam logic [1:0] CH_RIGHT = 2'd2;

  typedef struct packed {
    logic [15:0] threshold_level;
    logic [31:0] hangover_samples;
    logic [5:0]  preroll_frames;
    logic        preroll_enable;
    logic        stereo_mode;
    logic        eight_bit_mode;
  } cfg_t;

  // one request from front to back: a passed frame, plus replay count
  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic [5:0]  replay_n;
    logic        closing;
    logic [31:0] dur;
    logic [31:0] mark;
    logic [1:0]  chan;
  } cmd_t;

  typedef struct packed {
    logic [15:0] out_left;
    logic [15:0] out_right;
    logic        from_history;
    logic        last_of_run;
    logic        gate_closed_now;
    logic [31:0] event_duration;
    logic [31:0] event_mark_in;
    logic [1:0]  event_channel;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_EMIT,
    BK_PASS
  } bk_state_t;

endpackage

// ===== sv/asg_queue.sv =====
// Small FIFO between the gate front end and the output back end.
// Depends on asg_pkg for the queue depth.
module asg_queue import asg_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/asg_front.sv =====
// Gate front end: level detect, gate/hangover state, event counters,
// history write side. Depends on asg_pkg.
module asg_front import asg_pkg::*; #(
  parameter int HISTORY_DEPTH = HIST_DEPTH_DEF,
  localparam int AW = $clog2(HISTORY_DEPTH),
  localparam int FW = $clog2(HISTORY_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [15:0]   in_left,
  input  logic [15:0]   in_right,
  input  logic          q_full,
  output logic          push,
  output cmd_t          cmd,
  output logic [AW-1:0] base,
  input  logic          replay_done,
  output logic          hist_we,
  output logic [AW-1:0] hist_waddr,
  output logic [31:0]   hist_wdata
);

  logic          gate_open;
  logic [31:0]   quiet_count;
  logic [AW-1:0] wp;
  logic [FW-1:0] fill;
  logic [31:0]   passed;
  logic [31:0]   evlen;
  logic [31:0]   mark_in;
  logic [1:0]    trig;
  logic          replay_pend;
  logic          replay_start;
  logic [AW-1:0] hold_addr;
  logic [31:0]   hold_data;

  logic [15:0] lvl_l, lvl_r;
  logic        above_l, above_r, any_hit, opening, pass, closing, accept;
  logic [5:0]  avail, replay_n;
  logic [1:0]  trig_upd;
  logic [32:0] len_sum;
  logic [31:0] len_sat;

  // absolute level; byte mode maps b to (b - 128) * 256
  function automatic logic [15:0] level_of(input logic [15:0] raw, input logic eight);
    logic [8:0] d;
    logic [7:0] m;
    d = {1'b0, raw[7:0]} - 9'd128;
    m = d[8] ? 8'(-d) : d[7:0];
    if (eight) begin
      return {m, 8'h00};
    end
    return raw[15] ? 16'(-raw) : raw;
  endfunction

  assign in_ready = !q_full && !replay_pend;
  assign accept   = in_valid && in_ready;

  always_comb begin
    lvl_l    = level_of(in_left, cfg.eight_bit_mode);
    lvl_r    = level_of(in_right, cfg.eight_bit_mode);
    above_l  = lvl_l >= cfg.threshold_level;
    above_r  = cfg.stereo_mode && (lvl_r >= cfg.threshold_level);
    any_hit  = above_l || above_r;
    opening  = any_hit && !gate_open;
    pass     = any_hit || gate_open;
    closing  = !any_hit && gate_open && (quiet_count >= cfg.hangover_samples);
    avail    = (32'(cfg.preroll_frames) < 32'(fill)) ? cfg.preroll_frames : 6'(fill);
    replay_n = (opening && cfg.preroll_enable) ? avail : '0;
    base     = AW'((32'(wp) >= 32'(replay_n)) ? 32'(wp) - 32'(replay_n)
                   : 32'(wp) + 32'(HISTORY_DEPTH) - 32'(replay_n));
    trig_upd = above_l ? CH_LEFT : (above_r ? CH_RIGHT : trig);
    len_sum  = {1'b0, evlen} + 33'(replay_n) + 33'd1;
    len_sat  = len_sum[32] ? '1 : len_sum[31:0];

    cmd.left     = in_left;
    cmd.right    = in_right;
    cmd.replay_n = replay_n;
    cmd.closing  = closing;
    cmd.dur      = closing ? len_sat : '0;
    cmd.mark     = closing ? mark_in : '0;
    cmd.chan     = closing ? trig_upd : CH_NONE;
  end

  assign push         = accept && pass;
  assign replay_start = push && (replay_n != '0);

  // a replaying opening stores its own frame only once the replay is done,
  // so replaying the whole ring still reads the oldest frame
  assign hist_we    = (accept && !replay_start) || replay_done;
  assign hist_waddr = replay_pend ? hold_addr : wp;
  assign hist_wdata = replay_pend ? hold_data : {in_right, in_left};

  always_ff @(posedge clk) begin
    if (replay_start) begin
      hold_addr <= wp;
      hold_data <= {in_right, in_left};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_open   <= 1'b0;
      quiet_count <= '0;
      wp          <= '0;
      fill        <= '0;
      passed      <= '0;
      evlen       <= '0;
      mark_in     <= '0;
      trig        <= CH_NONE;
      replay_pend <= 1'b0;
    end else begin
      if (replay_start) begin
        replay_pend <= 1'b1;
      end else if (replay_done) begin
        replay_pend <= 1'b0;
      end
      if (accept) begin
        trig <= closing ? CH_NONE : trig_upd;
        if (any_hit) begin
          quiet_count <= '0;
        end else if (gate_open) begin
          quiet_count <= quiet_count + 1'b1;
        end
        if (opening) begin
          gate_open <= 1'b1;
          mark_in   <= passed;
        end else if (closing) begin
          gate_open <= 1'b0;
        end
        if (pass) begin
          passed <= passed + 32'(replay_n) + 32'd1;
          evlen  <= closing ? '0 : len_sat;
        end
        wp <= (wp == AW'(HISTORY_DEPTH - 1)) ? '0 : wp + 1'b1;
        if (fill != FW'(HISTORY_DEPTH)) begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/asg_back.sv =====
// Output back end: history ring memory, preroll replay sequencer and
// the output register. Depends on asg_pkg.
module asg_back import asg_pkg::*; #(
  parameter int HISTORY_DEPTH = HIST_DEPTH_DEF,
  localparam int AW = $clog2(HISTORY_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          hist_we,
  input  logic [AW-1:0] hist_waddr,
  input  logic [31:0]   hist_wdata,
  input  logic          q_valid,
  input  cmd_t          q_cmd,
  input  logic [AW-1:0] q_base,
  output logic          pop,
  output logic          replay_done,
  output logic          out_valid,
  input  logic          out_ready,
  output res_t          res
);

  logic [31:0] ring [HISTORY_DEPTH];

  bk_state_t     state, state_next;
  cmd_t          cur;
  logic [AW-1:0] rd_addr;
  logic [5:0]    remain;
  logic [31:0]   mem_q;
  logic          slot_free;
  logic          rd_en;
  logic          load_q, load_hist, load_cur, start_replay;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (hist_we) begin
      ring[hist_waddr] <= hist_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= ring[rd_addr];
    end
  end

  always_comb begin
    state_next   = state;
    pop          = 1'b0;
    rd_en        = 1'b0;
    load_q       = 1'b0;
    load_hist    = 1'b0;
    load_cur     = 1'b0;
    start_replay = 1'b0;
    replay_done  = 1'b0;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          if (q_cmd.replay_n != '0) begin
            pop          = 1'b1;
            start_replay = 1'b1;
            state_next   = BK_READ;
          end else if (slot_free) begin
            pop    = 1'b1;
            load_q = 1'b1;
          end
        end
      end
      BK_READ: begin
        rd_en      = 1'b1;
        state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (slot_free) begin
          load_hist  = 1'b1;
          state_next = (remain == 6'd1) ? BK_PASS : BK_READ;
        end
      end
      BK_PASS: begin
        if (slot_free) begin
          load_cur    = 1'b1;
          replay_done = 1'b1;
          state_next  = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start_replay) begin
      cur     <= q_cmd;
      rd_addr <= q_base;
      remain  <= q_cmd.replay_n;
    end else if (load_hist) begin
      rd_addr <= (rd_addr == AW'(HISTORY_DEPTH - 1)) ? '0 : rd_addr + 1'b1;
      remain  <= remain - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_q || load_hist || load_cur) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_hist) begin
      res.out_left        <= mem_q[15:0];
      res.out_right       <= cfg.stereo_mode ? mem_q[31:16] : '0;
      res.from_history    <= 1'b1;
      res.last_of_run     <= 1'b0;
      res.gate_closed_now <= 1'b0;
      res.event_duration  <= '0;
      res.event_mark_in   <= '0;
      res.event_channel   <= CH_NONE;
    end else if (load_q || load_cur) begin
      res.out_left        <= load_q ? q_cmd.left : cur.left;
      res.out_right       <= cfg.stereo_mode ? (load_q ? q_cmd.right : cur.right) : '0;
      res.from_history    <= 1'b0;
      res.last_of_run     <= 1'b1;
      res.gate_closed_now <= load_q ? q_cmd.closing : cur.closing;
      res.event_duration  <= load_q ? q_cmd.dur : cur.dur;
      res.event_mark_in   <= load_q ? q_cmd.mark : cur.mark;
      res.event_channel   <= load_q ? q_cmd.chan : cur.chan;
    end
  end

endmodule

// ===== sv/audio_squelch_gate_preroll.sv =====
// Squelch gate with hangover and preroll replay: top level, config registers.
// Depends on asg_pkg, asg_front, asg_queue and asg_back.
//
// One audio frame enters per request and yields zero or more output frames.
// A frame that passes straight through is written into the queue and then
// loaded into the output register; the block keeps one frame per cycle while
// the gate stays open or closed and the output is not stalled. When the gate
// opens with preroll on, the history ring is replayed oldest first: the back
// end picks up the request, then for each replayed frame does one memory read
// and one output load, and then loads the opening frame itself; input
// requests stall from that opening until the opening frame is loaded, since
// the ring must not be overwritten while it is read.
// Configuration is to be written by the user only while the block is idle;
// the block itself does not enforce this.
module audio_squelch_gate_preroll import asg_pkg::*; #(
  parameter int HISTORY_DEPTH = HIST_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // left_sample, right_sample
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_left, out_right, gate_closed_now, event_duration, event_mark_in,
  // event_channel, zero pad
  output logic [103:0] m_axis_tdata,
  output logic         m_axis_tuser,   // from_history
  output logic         m_axis_tlast    // last_of_run
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int QW = $bits(cmd_t) + AW;

  cfg_t          cfg;
  logic          q_full, q_valid, push, pop, replay_done;
  cmd_t          cmd, q_cmd;
  logic [AW-1:0] base, q_base;
  logic          hist_we;
  logic [AW-1:0] hist_waddr;
  logic [31:0]   hist_wdata;
  logic [QW-1:0] q_head;
  res_t          res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_level  <= 16'd16384;
      cfg.hangover_samples <= 32'd44100;
      cfg.preroll_frames   <= 6'd63;
      cfg.preroll_enable   <= 1'b1;
      cfg.stereo_mode      <= 1'b1;
      cfg.eight_bit_mode   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD:  cfg.threshold_level  <= cfg_data[15:0];
        CFG_HANGOVER:   cfg.hangover_samples <= cfg_data;
        CFG_PREROLL_N:  cfg.preroll_frames   <= cfg_data[5:0];
        CFG_PREROLL_EN: cfg.preroll_enable   <= cfg_data[0];
        CFG_STEREO:     cfg.stereo_mode      <= cfg_data[0];
        CFG_EIGHT_BIT:  cfg.eight_bit_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  asg_front #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_left     (s_axis_tdata[15:0]),
    .in_right    (s_axis_tdata[31:16]),
    .q_full      (q_full),
    .push        (push),
    .cmd         (cmd),
    .base        (base),
    .replay_done (replay_done),
    .hist_we     (hist_we),
    .hist_waddr  (hist_waddr),
    .hist_wdata  (hist_wdata)
  );

  asg_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({base, cmd}),
    .full      (q_full),
    .pop       (pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  assign q_cmd  = q_head[$bits(cmd_t)-1:0];
  assign q_base = q_head[QW-1:$bits(cmd_t)];

  asg_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .hist_we     (hist_we),
    .hist_waddr  (hist_waddr),
    .hist_wdata  (hist_wdata),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_base      (q_base),
    .pop         (pop),
    .replay_done (replay_done),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .res         (res)
  );

  assign m_axis_tdata = {5'b0, res.event_channel, res.event_mark_in, res.event_duration,
                         res.gate_closed_now, res.out_right, res.out_left};
  assign m_axis_tuser = res.from_history;
  assign m_axis_tlast = res.last_of_run;

endmodule
